FILE: hw/rtl/bq6_pkg.sv
package bq6_pkg;

  // Defaults for the top-level parameters
  localparam int SAMPLE_BITS_DEF   = 24;
  localparam int NUM_INSTANCES_DEF = 6;
  localparam int GUARD_BITS_DEF    = 8;

  // Width of the instance selector field
  localparam int SEL_BITS = 3;

  // Coefficients are halved Q1.23, whatever the sample width
  localparam int COEF_BITS = 24;
  localparam int COEF_FRAC = 23;

  localparam int NUM_KINDS = 3;
  localparam int KIND_BITS = 2;
  localparam int NUM_TAPS  = 5;

  typedef logic [KIND_BITS-1:0]         kind_t;
  typedef logic signed [COEF_BITS-1:0]  coef_t;

  // Filter kinds
  localparam kind_t KIND_LPF11 = 2'd0;
  localparam kind_t KIND_HPF3  = 2'd1;
  localparam kind_t KIND_HPF5  = 2'd2;

  // Tap order within a row: b0, b1, b2, a1, a2
  localparam int TAP_B0 = 0;
  localparam int TAP_B1 = 1;
  localparam int TAP_B2 = 2;
  localparam int TAP_A1 = 3;
  localparam int TAP_A2 = 4;

  localparam coef_t COEF_ROM [NUM_KINDS][NUM_TAPS] = '{
    '{ 24'sd1071933,  24'sd2143865, 24'sd1071933,  -24'sd643678,  24'sd737104 },
    '{ 24'sd3175536, -24'sd6351071, 24'sd3175536, -24'sd6099540, 24'sd2407790 },
    '{ 24'sd2629180, -24'sd5258361, 24'sd2629180, -24'sd4652443, 24'sd1669972 }
  };

  // Filter kind of an instance: selector mod 3
  function automatic kind_t kind_of(input logic [SEL_BITS-1:0] sel);
    kind_t k;
    unique case (sel)
      3'd0, 3'd3, 3'd6: k = KIND_LPF11;
      3'd1, 3'd4, 3'd7: k = KIND_HPF3;
      3'd2, 3'd5:       k = KIND_HPF5;
      default:          k = KIND_LPF11;
    endcase
    return k;
  endfunction

endpackage

FILE: hw/rtl/biquad_iir_six_instance.sv
// An input transfer loads the input register; the item then moves into the
// result register, where out_valid rises and the result waits to transfer out.
// Throughput: one sample per cycle while out_stall is low, back to back, even
// on the same instance; the five multiplies and the sum all sit in one stage
// between the input and result registers; history is written as results load.
// Reset (rst_n low, synchronous): both stages empty, all history words zero.
module biquad_iir_six_instance #(
  parameter int SAMPLE_BITS   = bq6_pkg::SAMPLE_BITS_DEF,
  parameter int NUM_INSTANCES = bq6_pkg::NUM_INSTANCES_DEF,
  parameter int GUARD_BITS    = bq6_pkg::GUARD_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,

  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic [bq6_pkg::SEL_BITS-1:0]  in_filter_select,

  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_filtered
);

  localparam int IDX_BITS = (NUM_INSTANCES > 1) ? $clog2(NUM_INSTANCES) : 1;

  // ---------------------------------------------------------------------------
  // Stage 1: input register
  // ---------------------------------------------------------------------------
  logic                          s1_valid_r, s1_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] s1_sample_r;
  logic [bq6_pkg::SEL_BITS-1:0]  s1_sel_r;

  // Result register
  logic                          out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_filtered_r;

  // Per-instance history: h1 newest, h2 one older
  logic signed [SAMPLE_BITS-1:0] in_h1_r  [NUM_INSTANCES];
  logic signed [SAMPLE_BITS-1:0] in_h2_r  [NUM_INSTANCES];
  logic signed [SAMPLE_BITS-1:0] out_h1_r [NUM_INSTANCES];
  logic signed [SAMPLE_BITS-1:0] out_h2_r [NUM_INSTANCES];

  logic                          out_load;   // result register takes a new value
  logic                          s1_fire;    // stage 1 item moves into result
  logic                          in_fire;    // input transfer
  logic                          in_range;
  logic [IDX_BITS-1:0]           s1_idx;
  logic signed [SAMPLE_BITS-1:0] mac_y;
  logic signed [SAMPLE_BITS-1:0] res;

  // Result register frees up when empty or its item is taken this cycle.
  assign out_load = !out_valid_r || !out_stall;
  // Stage 1 is blocked only when it holds an item and the result register
  // cannot take it, so a waiting result stops an input transfer only then.
  assign in_stall = s1_valid_r && !out_load;
  assign in_fire  = in_valid && !in_stall;
  assign s1_fire  = s1_valid_r && out_load;

  assign in_range = 32'(s1_sel_r) < 32'(NUM_INSTANCES);
  assign s1_idx   = in_range ? IDX_BITS'(s1_sel_r) : '0;

  // ---------------------------------------------------------------------------
  // Arithmetic: reads the instance's history combinationally
  // ---------------------------------------------------------------------------
  bq6_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .GUARD_BITS  (GUARD_BITS)
  ) u_mac (
    .kind (bq6_pkg::kind_of(s1_sel_r)),
    .x    (s1_sample_r),
    .xh1  (in_h1_r[s1_idx]),
    .xh2  (in_h2_r[s1_idx]),
    .yh1  (out_h1_r[s1_idx]),
    .yh2  (out_h2_r[s1_idx]),
    .y    (mac_y)
  );

  // Unknown instance gives zero and leaves history alone
  assign res = in_range ? mac_y : '0;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_sample_r <= in_sample;
      s1_sel_r    <= in_filter_select;
    end
    if (s1_fire) begin
      out_filtered_r <= res;
    end
  end

  // History: shift in the sample and the result as the result loads, so a
  // following item on the same instance already sees them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_INSTANCES; i++) begin
        in_h1_r[i]  <= '0;
        in_h2_r[i]  <= '0;
        out_h1_r[i] <= '0;
        out_h2_r[i] <= '0;
      end
    end else if (s1_fire && in_range) begin
      in_h2_r[s1_idx]  <= in_h1_r[s1_idx];
      in_h1_r[s1_idx]  <= s1_sample_r;
      out_h2_r[s1_idx] <= out_h1_r[s1_idx];
      out_h1_r[s1_idx] <= mac_y;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_filtered = out_filtered_r;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  // Input side only backs up when both stages are occupied
  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("in_stall with a free stage");

  // Unknown instance yields a zero result
  a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !in_range) |=> (out_valid_r && out_filtered_r == '0))
    else $error("out-of-range instance gave nonzero result");

  // The delivered result is the instance's newest output history
  a_hist_match: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && in_range) |=> (out_h1_r[$past(s1_idx)] == out_filtered_r))
    else $error("output history does not match result");

  // Unknown instance leaves instance 0's newest history words untouched
  a_oor_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && !in_range) |=> $stable(out_h1_r[0]) && $stable(in_h1_r[0]))
    else $error("history changed on out-of-range instance");

endmodule

FILE: hw/rtl/bq6_mac.sv
// Direct-form-1 biquad arithmetic: five floored products, wrapped sum,
// doubling and saturation. Purely combinational.
module bq6_mac #(
  parameter int SAMPLE_BITS = bq6_pkg::SAMPLE_BITS_DEF,
  parameter int GUARD_BITS  = bq6_pkg::GUARD_BITS_DEF
) (
  input  bq6_pkg::kind_t                kind,
  input  logic signed [SAMPLE_BITS-1:0] x,
  input  logic signed [SAMPLE_BITS-1:0] xh1,
  input  logic signed [SAMPLE_BITS-1:0] xh2,
  input  logic signed [SAMPLE_BITS-1:0] yh1,
  input  logic signed [SAMPLE_BITS-1:0] yh2,
  output logic signed [SAMPLE_BITS-1:0] y
);

  localparam int ACC_BITS  = SAMPLE_BITS + GUARD_BITS;
  localparam int PROD_BITS = bq6_pkg::COEF_BITS + SAMPLE_BITS;
  localparam int SH_BITS   = PROD_BITS - bq6_pkg::COEF_FRAC;

  logic signed [SAMPLE_BITS-1:0] opnd [bq6_pkg::NUM_TAPS];
  logic signed [PROD_BITS-1:0]   prod [bq6_pkg::NUM_TAPS];
  logic signed [SH_BITS-1:0]     prod_sh [bq6_pkg::NUM_TAPS];
  logic signed [ACC_BITS-1:0]    term [bq6_pkg::NUM_TAPS];
  logic signed [ACC_BITS-1:0]    acc;
  logic signed [ACC_BITS-1:0]    dbl;
  logic                          ovf;

  assign opnd[bq6_pkg::TAP_B0] = x;
  assign opnd[bq6_pkg::TAP_B1] = xh1;
  assign opnd[bq6_pkg::TAP_B2] = xh2;
  assign opnd[bq6_pkg::TAP_A1] = yh1;
  assign opnd[bq6_pkg::TAP_A2] = yh2;

  // Dropping the low fraction bits of a signed product floors it
  always_comb begin
    for (int k = 0; k < bq6_pkg::NUM_TAPS; k++) begin
      prod[k]    = bq6_pkg::COEF_ROM[kind][k] * opnd[k];
      prod_sh[k] = prod[k][PROD_BITS-1:bq6_pkg::COEF_FRAC];
      term[k]    = ACC_BITS'(prod_sh[k]);
    end
  end

  assign acc = term[bq6_pkg::TAP_B0] + term[bq6_pkg::TAP_B1] + term[bq6_pkg::TAP_B2]
             - term[bq6_pkg::TAP_A1] - term[bq6_pkg::TAP_A2];

  // Doubling wraps within the accumulator width
  assign dbl = {acc[ACC_BITS-2:0], 1'b0};

  assign ovf = (dbl[ACC_BITS-1:SAMPLE_BITS-1] != '0) &&
               (dbl[ACC_BITS-1:SAMPLE_BITS-1] != '1);

  always_comb begin
    if (!ovf) begin
      y = dbl[SAMPLE_BITS-1:0];
    end else if (dbl[ACC_BITS-1]) begin
      y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
    end else begin
      y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    end
  end

endmodule

FILE: bench/testbench.sv
`timescale 1ns / 1ps

module testbench;

  // Block configuration under test: package defaults
  localparam int SMP_W  = bq6_pkg::SAMPLE_BITS_DEF;
  localparam int N_INST = bq6_pkg::NUM_INSTANCES_DEF;
  localparam int ACC_W  = bq6_pkg::SAMPLE_BITS_DEF + bq6_pkg::GUARD_BITS_DEF;
  localparam int SEL_W  = bq6_pkg::SEL_BITS;

  localparam logic signed [SMP_W-1:0] SMP_MAX = {1'b0, {(SMP_W-1){1'b1}}};
  localparam logic signed [SMP_W-1:0] SMP_MIN = {1'b1, {(SMP_W-1){1'b0}}};
  localparam logic signed [SMP_W-1:0] SMP_ZERO = '0;
  localparam logic signed [SMP_W-1:0] SMP_NEG1 = '1;

  // Instance selectors
  localparam logic [SEL_W-1:0] INST_L_LPF11 = 3'd0;
  localparam logic [SEL_W-1:0] INST_L_HPF3  = 3'd1;
  localparam logic [SEL_W-1:0] INST_L_HPF5  = 3'd2;
  localparam logic [SEL_W-1:0] INST_R_LPF11 = 3'd3;
  localparam logic [SEL_W-1:0] INST_R_HPF3  = 3'd4;
  localparam logic [SEL_W-1:0] INST_R_HPF5  = 3'd5;
  // Selectors past the last instance: zero result, state untouched
  localparam logic [SEL_W-1:0] INST_NONE_A  = SEL_W'(N_INST);
  localparam logic [SEL_W-1:0] INST_NONE_B  = SEL_W'(N_INST + 1);

  // Halved Q1.23 taps per filter kind: b0, b1, b2, a1, a2
  localparam longint TAPS [3][5] = '{
    '{ 1071933,  2143865, 1071933,  -643678,  737104 },
    '{ 3175536, -6351071, 3175536, -6099540, 2407790 },
    '{ 2629180, -5258361, 2629180, -4652443, 1669972 }
  };

  localparam int PHASE_ITEMS = 284;   // least number of random transfers per random phase
  localparam int LONG_HOLD   = 60;    // cycles of forced out_stall
  localparam int DRAIN_CYC   = 8;     // margin after last result
  localparam int MAX_REPORTS = 10;

  // Directed stimulus; want is typed in only where it is obvious
  typedef struct packed {
    logic signed [SMP_W-1:0] smp;
    logic [SEL_W-1:0]        sel;
    logic                    typed;
    logic signed [SMP_W-1:0] want;
  } probe_t;

  localparam int N_PROBES = 22;
  localparam probe_t PROBES [N_PROBES] = '{
    '{SMP_ZERO, INST_L_LPF11, 1'b1, SMP_ZERO},   // fresh state, zero in: zero out
    '{SMP_MAX,  INST_L_LPF11, 1'b0, SMP_ZERO},
    '{SMP_MAX,  INST_L_LPF11, 1'b0, SMP_ZERO},
    '{SMP_MIN,  INST_L_LPF11, 1'b0, SMP_ZERO},
    '{SMP_MAX,  INST_L_HPF3,  1'b0, SMP_ZERO},
    '{SMP_MIN,  INST_L_HPF3,  1'b0, SMP_ZERO},   // full-scale step: clips low
    '{SMP_MIN,  INST_L_HPF3,  1'b0, SMP_ZERO},
    '{SMP_ZERO, INST_NONE_A,  1'b1, SMP_ZERO},   // no such instance
    '{SMP_MAX,  INST_NONE_B,  1'b1, SMP_ZERO},
    '{SMP_MAX,  INST_L_HPF3,  1'b0, SMP_ZERO},   // history must not have moved
    '{SMP_MIN,  INST_L_HPF5,  1'b0, SMP_ZERO},
    '{SMP_MAX,  INST_L_HPF5,  1'b0, SMP_ZERO},
    '{SMP_NEG1, INST_R_LPF11, 1'b0, SMP_ZERO},
    '{24'sd1,   INST_R_HPF3,  1'b0, SMP_ZERO},
    '{SMP_MAX,  INST_R_HPF5,  1'b0, SMP_ZERO},
    '{SMP_MIN,  INST_R_HPF5,  1'b0, SMP_ZERO},
    '{SMP_MAX,  INST_R_HPF5,  1'b0, SMP_ZERO},
    '{SMP_MIN,  INST_NONE_B,  1'b1, SMP_ZERO},
    '{24'h555555, INST_R_LPF11, 1'b0, SMP_ZERO},
    '{24'haaaaaa, INST_R_HPF3,  1'b0, SMP_ZERO},
    '{SMP_MIN,  INST_L_HPF3,  1'b0, SMP_ZERO},
    '{SMP_ZERO, INST_L_LPF11, 1'b0, SMP_ZERO}
  };

  logic                    clk;
  logic                    rst_n;
  logic                    in_valid;
  logic                    in_stall;
  logic signed [SMP_W-1:0] in_sample;
  logic [SEL_W-1:0]        in_filter_select;
  logic                    out_valid;
  logic                    out_stall;
  logic signed [SMP_W-1:0] out_filtered;

  // Bench-side tag riding with the current offer
  logic                    cur_typed;
  logic signed [SMP_W-1:0] cur_want;

  // Predictor state: per instance, newest at [2i], older at [2i+1]
  logic signed [SMP_W-1:0] x_hist [2*N_INST] = '{default: '0};
  logic signed [SMP_W-1:0] y_hist [2*N_INST] = '{default: '0};

  logic signed [SMP_W-1:0] expected_filtered [$];

  int send_idle_pct;
  int recv_stall_pct;
  bit long_hold_req = 1'b0;   // written by the sender only
  int mismatches = 0;
  int n_in = 0;
  int n_out = 0;
  int n_clip = 0;
  int n_none = 0;

  biquad_iir_six_instance uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_sample        (in_sample),
    .in_filter_select (in_filter_select),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_filtered     (out_filtered)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // One product, its 23 fraction bits dropped, truncated toward minus infinity
  function automatic longint tap_product(input longint coef, input logic signed [SMP_W-1:0] v);
    longint p;
    p = coef * longint'(v);
    return p >>> bq6_pkg::COEF_FRAC;
  endfunction

  // Filters one sample on one instance and advances that instance's history
  function automatic logic signed [SMP_W-1:0] run_biquad(input logic signed [SMP_W-1:0] x,
                                                         input logic [SEL_W-1:0] sel);
    longint                  acc;
    longint                  wide;
    logic signed [ACC_W-1:0] wrapped;
    logic signed [SMP_W-1:0] y;
    int                      kind;
    int                      base;
    if (int'(sel) >= N_INST) begin
      return '0;
    end
    kind = int'(sel) % 3;
    base = 2 * int'(sel);
    acc = tap_product(TAPS[kind][0], x)
        + tap_product(TAPS[kind][1], x_hist[base])
        + tap_product(TAPS[kind][2], x_hist[base+1])
        - tap_product(TAPS[kind][3], y_hist[base])
        - tap_product(TAPS[kind][4], y_hist[base+1]);
    acc = acc * 2;
    // doubled sum wraps in the guarded accumulator, then clips to the sample
    wrapped = acc[ACC_W-1:0];
    wide = longint'(wrapped);
    if (wide > longint'(SMP_MAX)) begin
      y = SMP_MAX;
    end else if (wide < longint'(SMP_MIN)) begin
      y = SMP_MIN;
    end else begin
      y = wide[SMP_W-1:0];
    end
    x_hist[base+1] = x_hist[base];
    x_hist[base]   = x;
    y_hist[base+1] = y_hist[base];
    y_hist[base]   = y;
    return y;
  endfunction

  // Sample mix: full-scale rails, small values near zero, and full random
  function automatic logic signed [SMP_W-1:0] pick_sample();
    case ($urandom_range(9))
      0:       return SMP_MAX;
      1:       return SMP_MIN;
      2:       return ($urandom_range(1) != 0) ? SMP_ZERO : SMP_NEG1;
      3, 4:    return SMP_W'(int'($urandom_range(4000)) - 2000);
      default: return SMP_W'($urandom);
    endcase
  endfunction

  function automatic logic [SEL_W-1:0] pick_instance();
    if ($urandom_range(99) < 6) begin
      return ($urandom_range(1) != 0) ? INST_NONE_A : INST_NONE_B;
    end
    return SEL_W'($urandom_range(N_INST - 1));
  endfunction

  // Offer one sample; returns at the falling edge after its transfer
  task automatic offer_sample(input logic signed [SMP_W-1:0] smp,
                              input logic [SEL_W-1:0] sel,
                              input logic typed,
                              input logic signed [SMP_W-1:0] want);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid         <= 1'b1;
    in_sample        <= smp;
    in_filter_select <= sel;
    cur_typed        <= typed;
    cur_want         <= want;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    @(negedge clk);
    n_in++;
  endtask

  // Receiver: random stall, plus one long forced hold-off on request
  initial begin : receiver
    int hold_left;
    bit hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && !hold_done) begin
        hold_left = LONG_HOLD;
        hold_done = 1'b1;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < recv_stall_pct);
      end
    end
  end

  // Scoreboard: predict on input transfer, check on result transfer.
  // Both sampled at the rising edge; the input and result registers keep an item's two transfers apart.
  always @(posedge clk) begin : scoreboard
    logic signed [SMP_W-1:0] y;
    logic signed [SMP_W-1:0] want;
    if (rst_n && in_valid && !in_stall) begin
      y = run_biquad(in_sample, in_filter_select);
      expected_filtered.push_back(cur_typed ? cur_want : y);
      if (int'(in_filter_select) >= N_INST) begin
        n_none++;
      end
    end
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (out_filtered == SMP_MAX || out_filtered == SMP_MIN) begin
        n_clip++;
      end
      if (expected_filtered.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS) begin
          $display("ERROR: result transfer %0d with nothing expected, filtered=%0d",
                   n_out, out_filtered);
        end
      end else begin
        want = expected_filtered.pop_front();
        if (out_filtered !== want) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS) begin
            $display("ERROR: result transfer %0d filtered expected %0d got %0d",
                     n_out, want, out_filtered);
          end
        end
      end
    end
  end

  // Stimulus: directed table, then three phases of random samples with differing idle and stall mixes
  initial begin : sender
    int                      phase;
    int                      sent;
    int                      burst_len;
    logic [SEL_W-1:0]        burst_sel;
    logic signed [SMP_W-1:0] level;

    rst_n            = 1'b0;
    in_valid         = 1'b0;
    in_sample        = '0;
    in_filter_select = '0;
    cur_typed        = 1'b0;
    cur_want         = '0;
    send_idle_pct    = 26;
    recv_stall_pct   = 83;

    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    for (int i = 0; i < N_PROBES; i++) begin
      offer_sample(PROBES[i].smp, PROBES[i].sel, PROBES[i].typed, PROBES[i].want);
    end

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0: begin send_idle_pct = 26; recv_stall_pct = 83; end
        1: begin send_idle_pct = 83; recv_stall_pct = 26; end
        default: begin
          send_idle_pct = 0;
          recv_stall_pct = 0;
          // receiver holds off while samples keep coming: pipeline fills up
          long_hold_req = 1'b1;
        end
      endcase
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        if ($urandom_range(9) == 0) begin
          // alternating full-scale steps on a high-pass: drives clipping
          burst_len = 4 + $urandom_range(4);
          burst_sel = (($urandom_range(1) != 0) ? INST_R_LPF11 : INST_L_LPF11)
                      + SEL_W'(1 + $urandom_range(1));
          level = ($urandom_range(1) != 0) ? SMP_MAX : SMP_MIN;
          for (int k = 0; k < burst_len; k++) begin
            offer_sample(level, burst_sel, 1'b0, SMP_ZERO);
            level = (level == SMP_MAX) ? SMP_MIN : SMP_MAX;
          end
          sent += burst_len;
        end else begin
          offer_sample(pick_sample(), pick_instance(), 1'b0, SMP_ZERO);
          sent++;
        end
      end
      if (phase == 0) begin
        // sender pauses until every result is back
        in_valid <= 1'b0;
        while (expected_filtered.size() != 0) begin
          @(posedge clk);
        end
        @(negedge clk);
      end
    end

    in_valid <= 1'b0;
    while (expected_filtered.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYC) @(posedge clk);

    $display("Covered %0d sample transfers on all six instances and invalid selectors (%0d),",
             n_in, n_none);
    $display("%0d results checked, %0d at full scale, over three stall/idle mixes.",
             n_out, n_clip);
    if (mismatches == 0 && expected_filtered.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin : watchdog
    #4000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
